// ===== hdl/first_fit_range_allocator_macros.svh =====
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define FFRA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies expectation in the next
`define FFRA_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define FFRA_ASSERT(name, prop, msg)
`define FFRA_ASSERT_NEXT(name, cond, conseq, msg)

`endif

`endif

// ===== hdl/ffra_pkg.sv =====
// Types, codes and constants of the first-fit range allocator.
package ffra_pkg;

  localparam int SLOT_BITS       = 12;
  localparam int LEN_BITS        = SLOT_BITS + 1;
  localparam int END_BITS        = SLOT_BITS + 2;
  localparam int DEF_MAX_EXTENTS = 32;

  localparam logic [LEN_BITS-1:0] SLOT_LIMIT  = {1'b1, {SLOT_BITS{1'b0}}};
  localparam logic [LEN_BITS-1:0] RESET_TOTAL = LEN_BITS'(256);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_SPACE = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_INVALID  = 2'd3;

  // table update selected by the decision stage
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE      = 3'd0;
  localparam op_t OP_SHRINK    = 3'd1;
  localparam op_t OP_REMOVE    = 3'd2;
  localparam op_t OP_FREE_BOTH = 3'd3;
  localparam op_t OP_FREE_NEXT = 3'd4;
  localparam op_t OP_FREE_PREV = 3'd5;
  localparam op_t OP_FREE_INS  = 3'd6;

  typedef struct packed {
    logic                action;
    logic [SLOT_BITS-1:0] slot_start;
    logic [LEN_BITS-1:0]  slot_count;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_BITS-1:0] allocated_slot;
  } rsp_t;

  typedef struct packed {
    logic req_load;
    logic flags_load;
    logic out_load;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic apply_needed;
  } stat_t;

endpackage

// ===== hdl/ffra_datapath.sv =====
// Extent table, per-entry compare, decision and update logic.
`include "first_fit_range_allocator_macros.svh"

module ffra_datapath
  import ffra_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [LEN_BITS-1:0] cfg_data,
  input  req_t                in_data,
  input  cmd_t                cmd,
  output stat_t               stat,
  output rsp_t                out_data
);

  localparam int IDX_W = $clog2(MAX_EXTENTS);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

  logic [SLOT_BITS-1:0] ext_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  ext_len   [MAX_EXTENTS];
  logic [CNT_W-1:0]     count;
  logic [LEN_BITS-1:0]  total;
  req_t                 req;

  logic [SLOT_BITS-1:0] start_next [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  len_next   [MAX_EXTENTS];
  logic [CNT_W-1:0]     count_next;

  logic [SLOT_BITS-1:0] above_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  above_len   [MAX_EXTENTS];
  logic [SLOT_BITS-1:0] below_start [MAX_EXTENTS];
  logic [LEN_BITS-1:0]  below_len   [MAX_EXTENTS];

  // per-entry compare results
  logic [MAX_EXTENTS-1:0] fit, exact, lt, ovl, prev_adj, next_adj;
  logic [MAX_EXTENTS-1:0] fit_q, exact_q, lt_q, prev_adj_q, next_adj_q;
  logic                   ovl_q, bad_q;
  logic [END_BITS-1:0]    req_end;
  logic                   bad;

  // decision
  logic [IDX_W-1:0]     k;
  logic                 found;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     pos_m1;
  logic                 join_prev, join_next;
  op_t                  op;
  logic [CNT_W-1:0]     idx;
  rsp_t                 rsp;
  op_t                  dec_op;
  logic [CNT_W-1:0]     dec_idx;

  logic [LEN_BITS-1:0]  cfg_sat;
  logic [LEN_BITS-1:0]  init_total;

  assign req_end = END_BITS'(req.slot_start) + END_BITS'(req.slot_count);
  assign bad     = (req.slot_count == '0) || (req_end > END_BITS'(total));

  for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
    logic                vld;
    logic [END_BITS-1:0] ee;

    assign vld = CNT_W'(g) < count;
    assign ee  = END_BITS'(ext_start[g]) + END_BITS'(ext_len[g]);

    assign fit[g]      = vld && (ext_len[g] >= req.slot_count);
    assign exact[g]    = ext_len[g] == req.slot_count;
    assign lt[g]       = vld && (ext_start[g] < req.slot_start);
    assign ovl[g]      = vld && (END_BITS'(req.slot_start) < ee)
                         && (END_BITS'(ext_start[g]) < req_end);
    assign prev_adj[g] = ee == END_BITS'(req.slot_start);
    assign next_adj[g] = END_BITS'(ext_start[g]) == req_end;

    if (g == MAX_EXTENTS - 1) begin : g_top
      assign above_start[g] = '0;
      assign above_len[g]   = '0;
    end else begin : g_mid
      assign above_start[g] = ext_start[g+1];
      assign above_len[g]   = ext_len[g+1];
    end

    if (g == 0) begin : g_bot
      assign below_start[g] = '0;
      assign below_len[g]   = '0;
    end else begin : g_up
      assign below_start[g] = ext_start[g-1];
      assign below_len[g]   = ext_len[g-1];
    end
  end

  // first fit and insert position; lt is a thermometer over sorted entries
  always_comb begin
    k   = '0;
    pos = CNT_W'(MAX_EXTENTS);
    for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
      if (fit_q[i]) begin
        k = IDX_W'(i);
      end
      if (!lt_q[i]) begin
        pos = CNT_W'(i);
      end
    end
  end

  assign found     = |fit_q;
  assign pos_m1    = pos - 1'b1;
  assign join_prev = (pos != '0) && prev_adj_q[pos_m1[IDX_W-1:0]];
  assign join_next = (pos < count) && next_adj_q[pos[IDX_W-1:0]];

  always_comb begin
    op                 = OP_NONE;
    idx                = pos;
    rsp.status         = ST_OK;
    rsp.allocated_slot = '0;
    if (req.action == ACT_ALLOC) begin
      idx = CNT_W'(k);
      if (found) begin
        rsp.allocated_slot = ext_start[k];
        op = (exact_q[k] && (req.slot_count != '0)) ? OP_REMOVE : OP_SHRINK;
      end else begin
        rsp.status = ST_NO_SPACE;
      end
    end else begin
      priority if (bad_q || ovl_q) begin
        rsp.status = ST_INVALID;
      end else if (join_prev && join_next) begin
        op = OP_FREE_BOTH;
      end else if (join_next) begin
        op = OP_FREE_NEXT;
      end else if (join_prev) begin
        op = OP_FREE_PREV;
      end else if (count == CNT_W'(MAX_EXTENTS)) begin
        rsp.status = ST_FULL;
      end else begin
        op = OP_FREE_INS;
      end
    end
  end

  assign stat.apply_needed = op != OP_NONE;

  // table update
  always_comb begin
    start_next = ext_start;
    len_next   = ext_len;
    count_next = count;
    if (cmd.apply) begin
      unique case (dec_op)
        OP_NONE: begin
        end
        OP_SHRINK: begin
          for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (CNT_W'(i) == dec_idx) begin
              start_next[i] = ext_start[i] + req.slot_count[SLOT_BITS-1:0];
              len_next[i]   = ext_len[i] - req.slot_count;
            end
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (CNT_W'(i) >= dec_idx) begin
              start_next[i] = above_start[i];
              len_next[i]   = above_len[i];
            end
          end
          count_next = count - 1'b1;
        end
        OP_FREE_BOTH: begin
          for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (CNT_W'(i + 1) == dec_idx) begin
              len_next[i] = ext_len[i] + req.slot_count + above_len[i];
            end else if (CNT_W'(i) >= dec_idx) begin
              start_next[i] = above_start[i];
              len_next[i]   = above_len[i];
            end
          end
          count_next = count - 1'b1;
        end
        OP_FREE_NEXT: begin
          for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (CNT_W'(i) == dec_idx) begin
              start_next[i] = req.slot_start;
              len_next[i]   = ext_len[i] + req.slot_count;
            end
          end
        end
        OP_FREE_PREV: begin
          for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (CNT_W'(i + 1) == dec_idx) begin
              len_next[i] = ext_len[i] + req.slot_count;
            end
          end
        end
        OP_FREE_INS: begin
          for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (CNT_W'(i) == dec_idx) begin
              start_next[i] = req.slot_start;
              len_next[i]   = req.slot_count;
            end else if (CNT_W'(i) > dec_idx) begin
              start_next[i] = below_start[i];
              len_next[i]   = below_len[i];
            end
          end
          count_next = count + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_sat    = (cfg_data > SLOT_LIMIT) ? SLOT_LIMIT : cfg_data;
  assign init_total = rst ? RESET_TOTAL : cfg_sat;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      total <= init_total;
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        ext_start[i] <= '0;
        ext_len[i]   <= (i == 0) ? init_total : '0;
      end
      count <= (init_total != '0) ? CNT_W'(1) : '0;
    end else begin
      ext_start <= start_next;
      ext_len   <= len_next;
      count     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req <= in_data;
    end
    if (cmd.flags_load) begin
      fit_q      <= fit;
      exact_q    <= exact;
      lt_q       <= lt;
      prev_adj_q <= prev_adj;
      next_adj_q <= next_adj;
      ovl_q      <= |ovl;
      bad_q      <= bad;
    end
    if (cmd.out_load) begin
      out_data <= rsp;
      dec_op   <= op;
      dec_idx  <= idx;
    end
  end

  `FFRA_ASSERT(a_count_bound, count <= CNT_W'(MAX_EXTENTS), "extent count beyond table size")
  `FFRA_ASSERT(a_insert_room, (cmd.apply && dec_op == OP_FREE_INS) |-> (count < CNT_W'(MAX_EXTENTS)), "insert into a full table")
  `FFRA_ASSERT_NEXT(a_remove_count, cmd.apply && (dec_op == OP_REMOVE || dec_op == OP_FREE_BOTH), count == $past(count) - 1'b1, "removal did not drop extent count")

endmodule

// ===== hdl/ffra_ctrl.sv =====
// Sequencer for compare, decide and update of one transaction at a time.
`include "first_fit_range_allocator_macros.svh"

module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_DEC   = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state, state_next;
  logic       accept;
  logic       out_free;

  assign in_stall = state != ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign cmd.req_load   = accept;
  assign cmd.flags_load = state == ST_CMP;
  assign cmd.out_load   = (state == ST_DEC) && out_free;
  assign cmd.apply      = state == ST_APPLY;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_DEC;
      end
      ST_DEC: begin
        // wait here until the result register is free
        if (out_free) begin
          state_next = stat.apply_needed ? ST_APPLY : ST_IDLE;
        end
      end
      ST_APPLY: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FFRA_ASSERT(a_load_when_free, cmd.out_load |-> !(out_valid && out_stall), "result overwritten while stalled")
  `FFRA_ASSERT_NEXT(a_accept_to_cmp, accept, state == ST_CMP, "accepted transaction not compared")
  `FFRA_ASSERT(a_apply_after_load, (state == ST_APPLY) |-> $past(cmd.out_load), "table update without a result")

endmodule

// ===== hdl/first_fit_range_allocator.sv =====
// Top level of the first-fit range allocator with coalescing free.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   cfg     | in        | cfg_write          | cfg_data: total_slots
//   in      | in        | in_valid/in_stall  | in_data: action, start, count
//   out     | out       | out_valid/out_stall| out_data: status, allocated_slot
//
// A transaction passes through the compare, decide and apply states when it
// changes the extent table and skips apply when it does not: compare across
// all entries, decide (priority pick), then a shift or merge update.
// The result is registered in the decide state, before the table update.
// Reset and a total_slots write both reload the table as one extent, or empty for a zero total.
// A stalled output holds the next transaction in its decision state.
`include "first_fit_range_allocator_macros.svh"

module first_fit_range_allocator
  import ffra_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [LEN_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  req_t                in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsp_t                out_data
);

  cmd_t  cmd;
  stat_t stat;

  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffra_datapath #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ===== verif/first_fit_range_allocator_checker.sv =====
// Channel monitor for the first-fit range allocator: predicts every result and compares it.
module first_fit_range_allocator_checker
  import ffra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [LEN_BITS-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  req_t                in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rsp_t                out_data,
  output int                  fails,
  output int                  pending
);

  localparam int NUM_EXT     = DEF_MAX_EXTENTS;
  localparam int MAX_REPORTS = 40;

  // free extent table, sorted by base, never touching
  int unsigned pool_size;
  int unsigned ext_base [NUM_EXT];
  int unsigned ext_len  [NUM_EXT];
  int unsigned ext_used;

  rsp_t grants_due [$];
  rsp_t want;
  int   err_count = 0;

  function automatic void reload_table(int unsigned total);
    pool_size = (total > SLOT_LIMIT) ? SLOT_LIMIT : total;
    for (int i = 0; i < NUM_EXT; i++) begin
      ext_base[i] = 0;
      ext_len[i]  = 0;
    end
    if (pool_size == 0) begin
      ext_used = 0;
    end else begin
      ext_used   = 1;
      ext_len[0] = pool_size;
    end
  endfunction

  function automatic void drop_extent(int unsigned pos);
    for (int unsigned i = pos; i + 1 < ext_used; i++) begin
      ext_base[i] = ext_base[i + 1];
      ext_len[i]  = ext_len[i + 1];
    end
    ext_used--;
    ext_base[ext_used] = 0;
    ext_len[ext_used]  = 0;
  endfunction

  function automatic rsp_t take_first_fit(int unsigned n);
    rsp_t g;
    g.status         = ST_NO_SPACE;
    g.allocated_slot = '0;
    for (int unsigned i = 0; i < ext_used; i++) begin
      if (ext_len[i] >= n) begin
        g.status         = ST_OK;
        g.allocated_slot = SLOT_BITS'(ext_base[i]);
        ext_base[i] += n;
        ext_len[i]  -= n;
        if (ext_len[i] == 0)
          drop_extent(i);
        return g;
      end
    end
    return g;
  endfunction

  function automatic status_t return_range(int unsigned s, int unsigned n);
    int unsigned stop;
    int unsigned pos;
    int unsigned e_end;
    bit          low_join;
    bit          high_join;
    stop = s + n;
    pos  = 0;
    if (n == 0 || stop > pool_size)
      return ST_INVALID;
    for (int unsigned i = 0; i < ext_used; i++) begin
      e_end = ext_base[i] + ext_len[i];
      if (s < e_end && ext_base[i] < stop)
        return ST_INVALID;
      if (ext_base[i] < s)
        pos = i + 1;
    end
    low_join  = pos > 0 && ext_base[pos - 1] + ext_len[pos - 1] == s;
    high_join = pos < ext_used && ext_base[pos] == stop;
    if (low_join && high_join) begin
      ext_len[pos - 1] += n + ext_len[pos];
      drop_extent(pos);
    end else if (high_join) begin
      ext_base[pos] = s;
      ext_len[pos] += n;
    end else if (low_join) begin
      ext_len[pos - 1] += n;
    end else begin
      if (ext_used >= NUM_EXT)
        return ST_FULL;
      for (int unsigned i = ext_used; i > pos; i--) begin
        ext_base[i] = ext_base[i - 1];
        ext_len[i]  = ext_len[i - 1];
      end
      ext_base[pos] = s;
      ext_len[pos]  = n;
      ext_used++;
    end
    return ST_OK;
  endfunction

  function automatic rsp_t predict_grant(req_t r);
    rsp_t g;
    if (r.action == ACT_ALLOC) begin
      g = take_first_fit(r.slot_count);
    end else begin
      g.status         = return_range(r.slot_start, r.slot_count);
      g.allocated_slot = '0;
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grants_due.delete();
      reload_table(RESET_TOTAL);
    end else begin
      if (cfg_write)
        reload_table(cfg_data);
      if (in_valid && !in_stall)
        grants_due.push_back(predict_grant(in_data));
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          report_mismatch("transaction with no result outstanding, status",
                          out_data.status, -1);
        end else begin
          want = grants_due.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.allocated_slot != want.allocated_slot)
            report_mismatch("allocated_slot", out_data.allocated_slot,
                            want.allocated_slot);
        end
      end
    end
    pending <= grants_due.size();
    fails   <= err_count;
  end

endmodule

// ===== verif/first_fit_range_allocator_tb.sv =====
// Stimulus, flow control and verdict for the first-fit range allocator.
module first_fit_range_allocator_tb;
  import ffra_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE         = 8;

  typedef struct {
    int unsigned base;
    int unsigned len;
  } span_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic [LEN_BITS-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  req_t                in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_data;
  int                  fails;
  int                  pending;

  span_t       held [$];      // ranges granted and not yet handed back
  req_t        sent_log [$];
  req_t        done_req;
  int unsigned cur_total   = 256;
  bit          quiet       = 1'b0;
  int          holds_asked = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;
  int          idle_cycles = 0;

  first_fit_range_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  first_fit_range_allocator_checker grant_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .fails    (fails),
    .pending  (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // track granted ranges so frees can hand back real allocations
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sent_log.push_back(in_data);
      if (out_valid && !out_stall && sent_log.size() > 0) begin
        done_req = sent_log.pop_front();
        if (done_req.action == ACT_ALLOC && out_data.status == ST_OK &&
            done_req.slot_count != 0)
          held.push_back('{out_data.allocated_slot, done_req.slot_count});
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("first_fit_range_allocator test failed");
      $finish;
    end
  end

  task automatic send_req(logic act, int unsigned start, int unsigned count);
    in_data  <= '{action: act, slot_start: SLOT_BITS'(start), slot_count: LEN_BITS'(count)};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // wait until every transaction has come back and the table update is done
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_total(int unsigned v);
    drain();
    cfg_data  <= LEN_BITS'(v);
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_total = (v > SLOT_LIMIT) ? SLOT_LIMIT : v;
    held.delete();
  endtask

  task automatic send_random(int items);
    int unsigned pick;
    int unsigned idx;
    int unsigned cut;
    int unsigned start;
    int unsigned count;
    span_t       sp;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      if (pick >= 45 && pick < 80 && held.size() > 0) begin
        idx = $urandom_range(held.size() - 1);
        sp  = held[idx];
        held.delete(idx);
        if (sp.len == 1 || $urandom_range(2) == 0) begin
          send_req(ACT_FREE, sp.base, sp.len);
        end else begin
          cut = $urandom_range(1, sp.len - 1);
          if ($urandom_range(1) == 0) begin
            held.push_back('{sp.base + cut, sp.len - cut});
            send_req(ACT_FREE, sp.base, cut);
          end else begin
            held.push_back('{sp.base, cut});
            send_req(ACT_FREE, sp.base + cut, sp.len - cut);
          end
        end
      end else if (pick >= 80) begin
        // mostly rejected frees: overlaps, zero length, past the end
        if ($urandom_range(3) == 0)
          start = $urandom_range(4095);
        else
          start = $urandom_range(cur_total > 0 ? cur_total - 1 : 0);
        case ($urandom_range(3))
          0:       count = 0;
          1:       count = $urandom_range(1, 8);
          2:       count = $urandom_range(8191);
          default: count = $urandom_range(1, cur_total + 1);
        endcase
        send_req(ACT_FREE, start, count);
      end else begin
        pick = $urandom_range(99);
        if (pick < 75)
          count = $urandom_range(1, cur_total / 16 + 1);
        else if (pick < 88)
          count = $urandom_range(cur_total);
        else if (pick < 94)
          count = 0;
        else
          count = $urandom_range(8191);
        send_req(ACT_ALLOC, $urandom_range(4095), count);
      end
    end
  endtask

  // chop the pool into many small pieces and hand back every other one
  task automatic fragment_pool();
    span_t spare [$];
    repeat (70) send_req(ACT_ALLOC, $urandom_range(4095), $urandom_range(1, 8));
    drain();
    spare = held;
    held.delete();
    foreach (spare[i]) begin
      if (i % 2 == 0)
        send_req(ACT_FREE, spare[i].base, spare[i].len);
      else
        held.push_back(spare[i]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: pool of 256 after reset
    send_req(ACT_ALLOC, 4095, 0);
    send_req(ACT_ALLOC, 0, 8191);
    send_req(ACT_ALLOC, 0, 4096);
    repeat (4) send_req(ACT_ALLOC, 0, 16);
    send_req(ACT_FREE, 16, 16);       // new extent
    send_req(ACT_FREE, 0, 8);         // new extent
    send_req(ACT_FREE, 32, 8);        // merge downward
    send_req(ACT_FREE, 48, 8);        // new extent
    send_req(ACT_FREE, 40, 8);        // merge both sides
    send_req(ACT_FREE, 56, 8);        // merge both sides
    send_req(ACT_FREE, 0, 1);         // starts where an extent starts
    send_req(ACT_FREE, 10, 0);
    send_req(ACT_FREE, 4095, 8191);
    send_req(ACT_FREE, 200, 100);     // runs past the end
    send_req(ACT_ALLOC, 0, 256);      // no extent is large enough
    send_req(ACT_ALLOC, 0, 1);
    send_req(ACT_ALLOC, 0, 0);
    send_req(ACT_FREE, 0, 256);
    send_req(ACT_ALLOC, 0, 255);
    send_req(ACT_FREE, 255, 1);
    send_random(150);

    set_total(4096);
    fragment_pool();
    send_random(60);
    quiet = 1'b1;
    send_random(80);
    quiet = 1'b0;
    holds_asked++;
    send_random(100);

    set_total(0);
    send_req(ACT_ALLOC, 0, 0);
    send_req(ACT_ALLOC, 0, 5);
    send_req(ACT_FREE, 0, 1);
    send_random(20);

    set_total(1);
    send_req(ACT_ALLOC, 0, 1);
    send_req(ACT_ALLOC, 0, 1);
    send_req(ACT_FREE, 0, 1);
    send_req(ACT_ALLOC, 0, 0);
    send_random(30);

    set_total(8191);                  // saturates to the full pool
    send_random(200);

    set_total($urandom_range(2, 4095));
    send_random(200);

    set_total(37);
    send_random(100);

    drain();
    if (fails == 0)
      $display("first_fit_range_allocator test passed");
    else
      $display("first_fit_range_allocator test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ffra_pkg.sv
hdl/ffra_datapath.sv
hdl/ffra_ctrl.sv
hdl/first_fit_range_allocator.sv
verif/first_fit_range_allocator_checker.sv
verif/first_fit_range_allocator_tb.sv
